### hdl/mvfe_pkg.sv
// Shared widths, constants, codes and lane result type for the mecanum velocity block.
package mvfe_pkg;

    // Field widths fixed by the interface
    localparam int OUT_W      = 32;
    localparam int STAMP_W    = 32;
    localparam int DT_W       = 32;
    localparam int RADIUS_W   = 20;
    localparam int LEN_W      = 20;
    localparam int COUNTS_W   = 16;
    localparam int GEAR_W     = 8;
    localparam int CG_W       = COUNTS_W + GEAR_W;
    localparam int GEO_W      = LEN_W + 1;
    localparam int CDIV_W     = CG_W + DT_W;
    localparam int CGEO_W     = CDIV_W + GEO_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WID   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR       = 3'd4;

    localparam logic [RADIUS_W-1:0] RADIUS_RST   = 20'd73400;
    localparam logic [LEN_W-1:0]    HALF_LEN_RST = 20'd209715;
    localparam logic [LEN_W-1:0]    HALF_WID_RST = 20'd177209;
    localparam logic [COUNTS_W-1:0] COUNTS_RST   = 16'd42;
    localparam logic [GEAR_W-1:0]   GEAR_RST     = 8'd5;

    // pi * 2^30 (rounded down) times microseconds per second, split in chunks
    localparam int K_W    = 52;
    localparam int K_CH_W = 18;
    localparam int K_N_CH = 3;
    localparam logic [K_N_CH*K_CH_W-1:0] K_PI_US = 54'd3373259426000000;

    // Scale of the radius (2^20) and of pi (2^30), plus 2^1 for the /4 and 2*pi
    localparam int RATE_SHIFT = 51;
    localparam int YAW_SHIFT  = 31;

    // Quotient bits kept by the divider: enough to tell a 32-bit overflow
    localparam int Q_W     = 33;
    localparam int Q_CNT_W = $clog2(Q_W);
    localparam logic [Q_W-1:0] LIM_POS = 33'h0_7FFF_FFFF;
    localparam logic [Q_W-1:0] LIM_NEG = 33'h0_8000_0000;

    localparam logic [OUT_W-1:0] OUT_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] OUT_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    typedef struct packed {
        logic             done;
        logic             sat;
        logic [OUT_W-1:0] value;
    } t_lane_res;

endpackage

### hdl/mvfe_lane.sv
// One velocity lane: |S|*r*K, restoring division by the lane divisor, saturate and sign.
module mvfe_lane #(
    parameter int MAG_W = 34,
    parameter int DIV_W = 92
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [MAG_W-1:0]           i_sum,
    input  logic [mvfe_pkg::RADIUS_W-1:0]     i_radius,
    input  logic [DIV_W-1:0]                  i_divisor,
    output mvfe_pkg::t_lane_res               o_res
);

    localparam int MR_W  = MAG_W + mvfe_pkg::RADIUS_W;
    localparam int NUM_W = MR_W + mvfe_pkg::K_W;
    localparam int HI_W  = NUM_W - mvfe_pkg::Q_W;
    localparam int CMP_W = (HI_W > DIV_W) ? HI_W : DIV_W;
    localparam int CHK_W = $clog2(mvfe_pkg::K_N_CH);
    localparam int Q_W   = mvfe_pkg::Q_W;
    localparam int OUT_W = mvfe_pkg::OUT_W;

    typedef enum logic [5:0] {
        L_IDLE = 6'b000001,
        L_MUL  = 6'b000010,
        L_ACC  = 6'b000100,
        L_PRE  = 6'b001000,
        L_DIV  = 6'b010000,
        L_FIN  = 6'b100000
    } t_lstate;

    t_lstate                       r_state, n_state;
    logic                          r_neg, n_neg;
    logic [MAG_W-1:0]              r_mag, n_mag;
    logic [MR_W-1:0]               r_mr, n_mr;
    logic [NUM_W-1:0]              r_num, n_num;
    logic [CHK_W-1:0]              r_chunk, n_chunk;
    logic [DIV_W-1:0]              r_rem, n_rem;
    logic [Q_W-1:0]                r_ql, n_ql;
    logic [mvfe_pkg::Q_CNT_W-1:0]  r_cnt, n_cnt;
    logic                          r_ovf, n_ovf;
    logic                          r_done, n_done;
    logic                          r_sat, n_sat;
    logic [OUT_W-1:0]              r_val, n_val;

    logic [mvfe_pkg::K_CH_W-1:0]   w_kchunk;
    logic [DIV_W:0]                w_part;
    logic [DIV_W:0]                w_diff;
    logic                          w_ge;
    logic [CMP_W-1:0]              w_hi;
    logic [Q_W-1:0]                w_lim;
    logic                          w_sat;
    logic [OUT_W-1:0]              w_mag_out;

    assign w_kchunk = mvfe_pkg::K_PI_US[r_chunk*mvfe_pkg::K_CH_W +: mvfe_pkg::K_CH_W];

    // One restoring step: bring in the next numerator bit from the top of r_ql
    assign w_part = {r_rem, r_ql[Q_W-1]};
    assign w_ge   = w_part >= {1'b0, i_divisor};
    assign w_diff = w_part - {1'b0, i_divisor};

    assign w_hi      = CMP_W'(r_num >> Q_W);
    assign w_lim     = r_neg ? mvfe_pkg::LIM_NEG : mvfe_pkg::LIM_POS;
    assign w_sat     = r_ovf || (r_ql > w_lim);
    assign w_mag_out = w_sat ? w_lim[OUT_W-1:0] : r_ql[OUT_W-1:0];

    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_mr    = r_mr;
        n_num   = r_num;
        n_chunk = r_chunk;
        n_rem   = r_rem;
        n_ql    = r_ql;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_done  = 1'b0;
        n_sat   = r_sat;
        n_val   = r_val;
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_neg   = i_sum[MAG_W-1];
                    n_mag   = i_sum[MAG_W-1] ? MAG_W'(-i_sum) : MAG_W'(i_sum);
                    n_state = L_MUL;
                end
            end
            L_MUL: begin
                n_mr    = r_mag * i_radius;
                n_num   = '0;
                n_chunk = '0;
                n_state = L_ACC;
            end
            L_ACC: begin
                n_num   = r_num + (NUM_W'(r_mr * w_kchunk) << (r_chunk * mvfe_pkg::K_CH_W));
                n_chunk = r_chunk + 1'b1;
                if (r_chunk == CHK_W'(mvfe_pkg::K_N_CH - 1)) begin
                    n_state = L_PRE;
                end
            end
            L_PRE: begin
                // a quotient beyond Q_W bits is an overflow outright
                n_ovf   = w_hi >= CMP_W'(i_divisor);
                n_rem   = DIV_W'(r_num >> Q_W);
                n_ql    = r_num[Q_W-1:0];
                n_cnt   = mvfe_pkg::Q_CNT_W'(Q_W - 1);
                n_state = L_DIV;
            end
            L_DIV: begin
                n_rem = w_ge ? w_diff[DIV_W-1:0] : w_part[DIV_W-1:0];
                n_ql  = {r_ql[Q_W-2:0], w_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = L_FIN;
                end
            end
            L_FIN: begin
                n_sat   = w_sat;
                n_val   = r_neg ? (~w_mag_out + 1'b1) : w_mag_out;
                n_done  = 1'b1;
                n_state = L_IDLE;
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_mr    <= n_mr;
        r_num   <= n_num;
        r_chunk <= n_chunk;
        r_rem   <= n_rem;
        r_ql    <= n_ql;
        r_cnt   <= n_cnt;
        r_ovf   <= n_ovf;
        r_sat   <= n_sat;
        r_val   <= n_val;
    end

    assign o_res = '{done: r_done, sat: r_sat, value: r_val};

endmodule

### hdl/mecanum_velocity_from_encoders.sv
// Mecanum velocity from four encoder counts: front end, three parallel lanes, merging output stage.
//
// Each accepted item yields one result. The tick and time deltas are registered on accept;
// S_DEN then starts the three lanes (forward, lateral, yaw) and forms the count divisor, and
// S_GEO the yaw divisor. Each lane forms |S|*radius, adds in the pi constant chunk by chunk,
// checks for overflow and runs a restoring divider, one step per cycle, and registers the
// result; this loads the output register once that is free. A new item is taken only after
// that load, and a finished result may wait in the output register without holding up the
// next item. There is no clearing pass after reset. Configuration writes are taken in any cycle.
module mecanum_velocity_from_encoders #(
    parameter int TICK_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [mvfe_pkg::STAMP_W-1:0]         i_stamp_us,
    input  logic signed [31:0]                   i_ticks_front_left,
    input  logic signed [31:0]                   i_ticks_front_right,
    input  logic signed [31:0]                   i_ticks_rear_left,
    input  logic signed [31:0]                   i_ticks_rear_right,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [mvfe_pkg::OUT_W-1:0]    o_speed_forward,
    output logic signed [mvfe_pkg::OUT_W-1:0]    o_speed_lateral,
    output logic signed [mvfe_pkg::OUT_W-1:0]    o_yaw_rate,
    output logic [mvfe_pkg::STAMP_W-1:0]         o_stamp_out,
    output logic [1:0]                           o_status,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mvfe_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mvfe_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int MAG_W   = TICK_WIDTH + 2;
    localparam int DIV_W   = mvfe_pkg::CGEO_W + mvfe_pkg::YAW_SHIFT - FRAC_BITS;
    localparam int SHIFT_S = mvfe_pkg::RATE_SHIFT - FRAC_BITS;
    localparam int SHIFT_Y = mvfe_pkg::YAW_SHIFT - FRAC_BITS;
    localparam int N_LANES = 3;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEN  = 5'b00010,
        S_GEO  = 5'b00100,
        S_WAIT = 5'b01000,
        S_HOLD = 5'b10000
    } t_state;

    t_state                             r_state, n_state;

    // configuration
    logic [mvfe_pkg::RADIUS_W-1:0]      r_radius;
    logic [mvfe_pkg::LEN_W-1:0]         r_half_len;
    logic [mvfe_pkg::LEN_W-1:0]         r_half_wid;
    logic [mvfe_pkg::COUNTS_W-1:0]      r_counts;
    logic [mvfe_pkg::GEAR_W-1:0]        r_gear;
    logic [mvfe_pkg::CG_W-1:0]          r_cg;
    logic [mvfe_pkg::GEO_W-1:0]         r_geo;

    // history and per-item front end
    logic [TICK_WIDTH-1:0]              r_prev_ticks [4];
    logic [mvfe_pkg::STAMP_W-1:0]       r_prev_stamp;
    logic [TICK_WIDTH-1:0]              w_ticks [4];
    logic signed [TICK_WIDTH-1:0]       r_delta [4];
    logic signed [MAG_W-1:0]            w_d [4];
    logic [mvfe_pkg::DT_W-1:0]          r_dt;
    logic [mvfe_pkg::STAMP_W-1:0]       r_stamp;
    logic [mvfe_pkg::CDIV_W-1:0]        r_cdiv;
    logic [mvfe_pkg::CGEO_W-1:0]        r_cgeo;

    // lanes
    logic signed [MAG_W-1:0]            w_sum [N_LANES];
    logic [DIV_W-1:0]                   w_div [N_LANES];
    mvfe_pkg::t_lane_res                w_res [N_LANES];
    logic                               w_start;

    // output stage
    logic                               r_out_valid;
    logic [mvfe_pkg::OUT_W-1:0]         r_fwd;
    logic [mvfe_pkg::OUT_W-1:0]         r_lat;
    logic [mvfe_pkg::OUT_W-1:0]         r_yaw;
    logic [mvfe_pkg::STAMP_W-1:0]       r_stamp_out;
    mvfe_pkg::t_status                  r_status;
    logic                               w_in_acc;
    logic                               w_out_free;
    logic                               w_load;
    logic                               w_zero;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && o_ready;
    assign w_out_free  = !r_out_valid || i_ready;
    assign w_start     = (r_state == S_DEN);

    assign w_ticks[0] = i_ticks_front_left[TICK_WIDTH-1:0];
    assign w_ticks[1] = i_ticks_front_right[TICK_WIDTH-1:0];
    assign w_ticks[2] = i_ticks_rear_left[TICK_WIDTH-1:0];
    assign w_ticks[3] = i_ticks_rear_right[TICK_WIDTH-1:0];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_d[i] = MAG_W'(r_delta[i]);
        end
    end

    // wheel combinations: forward, lateral, yaw
    assign w_sum[0] = w_d[0] + w_d[1] + w_d[2] + w_d[3];
    assign w_sum[1] = -w_d[0] + w_d[1] + w_d[2] - w_d[3];
    assign w_sum[2] = -w_d[0] + w_d[1] - w_d[2] + w_d[3];

    assign w_div[0] = DIV_W'(r_cdiv) << SHIFT_S;
    assign w_div[1] = DIV_W'(r_cdiv) << SHIFT_S;
    assign w_div[2] = DIV_W'(r_cgeo) << SHIFT_Y;

    for (genvar g = 0; g < N_LANES; g++) begin : g_lane
        mvfe_lane #(
            .MAG_W (MAG_W),
            .DIV_W (DIV_W)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_start   (w_start),
            .i_sum     (w_sum[g]),
            .i_radius  (r_radius),
            .i_divisor (w_div[g]),
            .o_res     (w_res[g])
        );
    end

    assign w_zero = (r_cdiv == '0) || (r_geo == '0);

    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DEN;
                end
            end
            S_DEN: begin
                n_state = S_GEO;
            end
            S_GEO: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_res[0].done) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                // lanes keep their results until the output register frees up
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_radius     <= mvfe_pkg::RADIUS_RST;
            r_half_len   <= mvfe_pkg::HALF_LEN_RST;
            r_half_wid   <= mvfe_pkg::HALF_WID_RST;
            r_counts     <= mvfe_pkg::COUNTS_RST;
            r_gear       <= mvfe_pkg::GEAR_RST;
            r_prev_stamp <= '0;
            for (int i = 0; i < 4; i++) begin
                r_prev_ticks[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    mvfe_pkg::CFG_RADIUS:   r_radius   <= i_cfg_data[mvfe_pkg::RADIUS_W-1:0];
                    mvfe_pkg::CFG_HALF_LEN: r_half_len <= i_cfg_data[mvfe_pkg::LEN_W-1:0];
                    mvfe_pkg::CFG_HALF_WID: r_half_wid <= i_cfg_data[mvfe_pkg::LEN_W-1:0];
                    mvfe_pkg::CFG_COUNTS:   r_counts   <= i_cfg_data[mvfe_pkg::COUNTS_W-1:0];
                    mvfe_pkg::CFG_GEAR:     r_gear     <= i_cfg_data[mvfe_pkg::GEAR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_in_acc) begin
                r_prev_stamp <= i_stamp_us;
                for (int i = 0; i < 4; i++) begin
                    r_prev_ticks[i] <= w_ticks[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cg  <= r_counts * r_gear;
        r_geo <= mvfe_pkg::GEO_W'(r_half_len) + mvfe_pkg::GEO_W'(r_half_wid);
        if (w_in_acc) begin
            r_dt    <= i_stamp_us - r_prev_stamp;
            r_stamp <= i_stamp_us;
            for (int i = 0; i < 4; i++) begin
                r_delta[i] <= w_ticks[i] - r_prev_ticks[i];
            end
        end
        if (r_state == S_DEN) begin
            r_cdiv <= r_dt * r_cg;
        end
        if (r_state == S_GEO) begin
            r_cgeo <= r_cdiv * r_geo;
        end
        if (w_load) begin
            r_stamp_out <= r_stamp;
            if (w_zero) begin
                r_fwd    <= '0;
                r_lat    <= '0;
                r_yaw    <= '0;
                r_status <= mvfe_pkg::ST_ZERO;
            end else begin
                r_fwd    <= w_res[0].value;
                r_lat    <= w_res[1].value;
                r_yaw    <= w_res[2].value;
                r_status <= (w_res[0].sat || w_res[1].sat || w_res[2].sat) ?
                            mvfe_pkg::ST_SAT : mvfe_pkg::ST_OK;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_speed_forward = r_fwd;
    assign o_speed_lateral = r_lat;
    assign o_yaw_rate      = r_yaw;
    assign o_stamp_out     = r_stamp_out;
    assign o_status        = r_status;

`ifndef ASSERT_OFF
    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res[0].done == w_res[1].done) && (w_res[0].done == w_res[2].done))
        else $error("lanes finished out of step");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res[0].done |-> (r_state == S_WAIT))
        else $error("lane result arrived while not waiting for it");

    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == mvfe_pkg::ST_ZERO)) |->
        ((o_speed_forward == '0) && (o_speed_lateral == '0) && (o_yaw_rate == '0)))
        else $error("flagged item carries nonzero speeds");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == mvfe_pkg::ST_SAT)) |->
        ((o_speed_forward == mvfe_pkg::OUT_MAX) || (o_speed_forward == mvfe_pkg::OUT_MIN) ||
         (o_speed_lateral == mvfe_pkg::OUT_MAX) || (o_speed_lateral == mvfe_pkg::OUT_MIN) ||
         (o_yaw_rate == mvfe_pkg::OUT_MAX) || (o_yaw_rate == mvfe_pkg::OUT_MIN)))
        else $error("saturation reported without a clipped output");
`endif

endmodule

### bench/tb.sv
// Self-checking bench for the mecanum velocity block: random-gap handshakes, local predictor.
`timescale 1ns / 1ps

module tb;

    localparam int FRAC = 16;
    localparam logic [63:0] PI_US = 64'd3373259426000000;
    localparam int CYCLE_LIMIT = 2000000;

    // Indexes the block does not decode
    localparam logic [mvfe_pkg::CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd5;
    localparam logic [mvfe_pkg::CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd6;
    localparam logic [mvfe_pkg::CFG_IDX_W-1:0] CFG_UNUSED_C = 3'd7;

    typedef struct packed {
        logic [31:0]       stamp;
        logic [3:0][31:0]  ticks;   // front-left, front-right, rear-left, rear-right
    } t_sample;

    typedef struct packed {
        logic [31:0]       fwd;
        logic [31:0]       lat;
        logic [31:0]       yaw;
        logic [31:0]       stamp;
        mvfe_pkg::t_status status;
    } t_velocity;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic [31:0] in_stamp = '0;
    logic [31:0] in_fl = '0;
    logic [31:0] in_fr = '0;
    logic [31:0] in_rl = '0;
    logic [31:0] in_rr = '0;
    logic        out_ready = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic [mvfe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mvfe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_speed_forward;
    logic [31:0] o_speed_lateral;
    logic [31:0] o_yaw_rate;
    logic [31:0] o_stamp_out;
    logic [1:0]  o_status;
    logic        o_cfg_ready;

    // Predictor copy of the registers and the stored counts
    logic [mvfe_pkg::RADIUS_W-1:0] cfg_radius   = mvfe_pkg::RADIUS_RST;
    logic [mvfe_pkg::LEN_W-1:0]    cfg_half_len = mvfe_pkg::HALF_LEN_RST;
    logic [mvfe_pkg::LEN_W-1:0]    cfg_half_wid = mvfe_pkg::HALF_WID_RST;
    logic [mvfe_pkg::COUNTS_W-1:0] cfg_counts   = mvfe_pkg::COUNTS_RST;
    logic [mvfe_pkg::GEAR_W-1:0]   cfg_gear     = mvfe_pkg::GEAR_RST;
    logic [3:0][31:0]              prior_ticks  = '0;
    logic [31:0]                   last_stamp   = '0;

    // Generator's view of the last queued sample
    logic [31:0]      gen_stamp = '0;
    logic [3:0][31:0] gen_ticks = '0;

    t_sample   sample_q[$];
    t_velocity velocity_q[$];
    t_sample   held;

    int queued_count = 0;
    int accepted_count = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int settings_count = 0;
    int cycle_count = 0;
    int feed_gap = 0;
    int feed_calm = 0;
    int sink_gap = 0;
    int sink_calm = 0;

    mecanum_velocity_from_encoders dut (
        .i_clk               (i_clk),
        .i_rst_n             (rst_n),
        .i_valid             (in_valid),
        .o_ready             (o_ready),
        .i_stamp_us          (in_stamp),
        .i_ticks_front_left  (in_fl),
        .i_ticks_front_right (in_fr),
        .i_ticks_rear_left   (in_rl),
        .i_ticks_rear_right  (in_rr),
        .o_valid             (o_valid),
        .i_ready             (out_ready),
        .o_speed_forward     (o_speed_forward),
        .o_speed_lateral     (o_speed_lateral),
        .o_yaw_rate          (o_yaw_rate),
        .o_stamp_out         (o_stamp_out),
        .o_status            (o_status),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb failed");
            $finish;
        end
    end

    // Mostly short gaps, some long ones, and now and then a calm stretch with none
    function automatic int next_gap(inout int calm);
        int pick;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 96) return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    // Scale one wheel combination to Q16.16, truncating the magnitude, with saturation
    function automatic logic [31:0] scale_sum(input logic signed [35:0] s,
                                              input logic [63:0] cdiv,
                                              input logic [63:0] geo,
                                              input int shift,
                                              inout logic sat);
        logic         neg;
        logic [35:0]  mag;
        logic [127:0] v;
        logic [127:0] lim;
        neg = s < 0;
        mag = neg ? -s : s;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        v = 128'(mag) * 128'(cfg_radius) * 128'(PI_US);
        v = v / 128'(cdiv);
        if (geo != 0) v = v / 128'(geo);
        v = v >> shift;
        if (v > lim) begin
            sat = 1'b1;
            v = lim;
        end
        return neg ? 32'd0 - v[31:0] : v[31:0];
    endfunction

    function automatic t_velocity predict_velocity(input t_sample smp);
        t_velocity          r;
        logic signed [31:0] step;
        logic signed [35:0] d [4];
        logic signed [35:0] s_fwd;
        logic signed [35:0] s_lat;
        logic signed [35:0] s_yaw;
        logic [31:0]        dt;
        logic [63:0]        geo;
        logic [63:0]        cdiv;
        logic               sat;
        dt = smp.stamp - last_stamp;
        for (int i = 0; i < 4; i++) begin
            step = smp.ticks[i] - prior_ticks[i];
            d[i] = step;
            prior_ticks[i] = smp.ticks[i];
        end
        last_stamp = smp.stamp;
        geo = 64'(cfg_half_len) + 64'(cfg_half_wid);
        cdiv = 64'(cfg_counts) * 64'(cfg_gear) * 64'(dt);
        r.stamp = smp.stamp;
        if (cdiv == 0 || geo == 0) begin
            r.fwd = '0;
            r.lat = '0;
            r.yaw = '0;
            r.status = mvfe_pkg::ST_ZERO;
        end else begin
            sat = 1'b0;
            s_fwd = d[0] + d[1] + d[2] + d[3];
            s_lat = -d[0] + d[1] + d[2] - d[3];
            s_yaw = -d[0] + d[1] - d[2] + d[3];
            r.fwd = scale_sum(s_fwd, cdiv, 64'd0, 51 - FRAC, sat);
            r.lat = scale_sum(s_lat, cdiv, 64'd0, 51 - FRAC, sat);
            r.yaw = scale_sum(s_yaw, cdiv, geo, 31 - FRAC, sat);
            r.status = sat ? mvfe_pkg::ST_SAT : mvfe_pkg::ST_OK;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %h, want %h",
                                      results_checked, name, got, want));
    endtask

    task automatic check_velocity();
        t_velocity want;
        if (velocity_q.size() == 0) begin
            report_mismatch($sformatf("result with no item waiting, stamp %h", o_stamp_out));
        end else begin
            want = velocity_q.pop_front();
            check_field("speed_forward", o_speed_forward, want.fwd);
            check_field("speed_lateral", o_speed_lateral, want.lat);
            check_field("yaw_rate", o_yaw_rate, want.yaw);
            check_field("stamp_out", o_stamp_out, want.stamp);
            check_field("status", 32'(o_status), 32'(want.status));
            results_checked++;
        end
    endtask

    // Driver: hold each item until taken, then wait out a random gap
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_ready) begin
                velocity_q.push_back(predict_velocity(held));
                accepted_count++;
            end
            if (!in_valid || o_ready) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                    in_valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    held = sample_q.pop_front();
                    in_stamp <= held.stamp;
                    in_fl <= held.ticks[0];
                    in_fr <= held.ticks[1];
                    in_rl <= held.ticks[2];
                    in_rr <= held.ticks[3];
                    in_valid <= 1'b1;
                    feed_gap = next_gap(feed_calm);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken result, stall at random
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_valid && out_ready) begin
                check_velocity();
                sink_gap = next_gap(sink_calm);
            end else if (sink_gap > 0) begin
                sink_gap--;
            end else if (!o_valid && $urandom_range(0, 15) == 0) begin
                sink_gap = $urandom_range(1, 5);
            end
            out_ready <= (sink_gap == 0);
        end
    end

    task automatic queue_sample(input logic [31:0] stamp, input logic [31:0] fl,
                                input logic [31:0] fr, input logic [31:0] rl,
                                input logic [31:0] rr);
        t_sample smp;
        smp.stamp = stamp;
        smp.ticks = {rr, rl, fr, fl};
        sample_q.push_back(smp);
        gen_stamp = stamp;
        gen_ticks = smp.ticks;
        queued_count++;
    endtask

    function automatic logic [31:0] nudge(input logic [31:0] base, input int span);
        return base + 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    // Mostly plausible motion at sample rates; the rest bursts, repeats, and noise
    task automatic queue_random();
        logic [31:0]      st;
        logic [3:0][31:0] tk;
        int               kind;
        int               span;
        kind = $urandom_range(0, 99);
        span = 2000;
        if (kind < 70) begin
            st = gen_stamp + $urandom_range(200, 20000);
        end else if (kind < 78) begin
            st = gen_stamp + $urandom_range(1, 50);
            span = 1 << 20;
        end else if (kind < 83) begin
            st = gen_stamp;
            span = 500;
        end else begin
            st = $urandom;
        end
        for (int i = 0; i < 4; i++) begin
            if (kind < 83) tk[i] = nudge(gen_ticks[i], span);
            else if (kind < 88) tk[i] = nudge(32'h8000_0000, 64);
            else tk[i] = $urandom;
        end
        queue_sample(st, tk[0], tk[1], tk[2], tk[3]);
    endtask

    // Wait until every queued item has been taken and its result checked
    task automatic settle();
        while (accepted_count != queued_count || velocity_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int n);
        settings_count++;
        repeat (n) queue_random();
        settle();
    endtask

    task automatic write_reg(input logic [mvfe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mvfe_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            mvfe_pkg::CFG_RADIUS:   cfg_radius = data[mvfe_pkg::RADIUS_W-1:0];
            mvfe_pkg::CFG_HALF_LEN: cfg_half_len = data[mvfe_pkg::LEN_W-1:0];
            mvfe_pkg::CFG_HALF_WID: cfg_half_wid = data[mvfe_pkg::LEN_W-1:0];
            mvfe_pkg::CFG_COUNTS:   cfg_counts = data[mvfe_pkg::COUNTS_W-1:0];
            mvfe_pkg::CFG_GEAR:     cfg_gear = data[mvfe_pkg::GEAR_W-1:0];
            default:      ;
        endcase
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;

        // First item measures against zero counts and time zero
        queue_sample(32'd1000, 32'd100, 32'd100, 32'd100, 32'd100);
        queue_sample(32'd1000, 32'd150, 32'd50, 32'd150, 32'd50);      // zero interval
        queue_sample(32'd2000, 32'd100, 32'd150, 32'd250, 32'd0);      // lateral
        queue_sample(32'd12000, 32'd50, 32'd200, 32'd200, 32'd50);     // yaw
        queue_sample(32'd22000, 32'd100, 32'd150, 32'd250, 32'd0);     // reverse yaw
        queue_sample(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);       // huge interval
        queue_sample(32'h0000_0010, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF);                    // stamp wraps, saturate
        queue_sample(32'h0000_0011, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000);                    // counts wrap by one
        queue_sample(32'h0000_0012, 32'h0, 32'h0, 32'h0, 32'h0);       // most negative deltas
        queue_sample(32'h0000_0013, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h8000_0000);
        queue_sample(32'h0000_0014, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_sample(32'h0000_4000, 32'hFFFF_FFCE, 32'h0000_0031,
                     32'hFFFF_FFCE, 32'h0000_0031);
        queue_sample(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'hAAAA_AAAA);
        queue_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'h5555_5555);
        queue_sample(32'h5555_5556, 32'hAAAA_AAAB, 32'h5555_5554,
                     32'hAAAA_AAA9, 32'h5555_5556);                    // one microsecond
        queue_sample(32'h0000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        run_phase(130);

        // Zero geometry, plus writes the block must ignore
        write_reg(mvfe_pkg::CFG_HALF_LEN, '0);
        write_reg(mvfe_pkg::CFG_HALF_WID, '0);
        write_reg(mvfe_pkg::CFG_RADIUS, 20'd1);
        write_reg(CFG_UNUSED_A, 20'hFFFFF);
        write_reg(CFG_UNUSED_B, 20'h5A5A5);
        write_reg(CFG_UNUSED_C, 20'hFFFFF);
        run_phase(60);

        // Every register at its top value; wide data masked to width
        write_reg(mvfe_pkg::CFG_RADIUS, 20'hFFFFF);
        write_reg(mvfe_pkg::CFG_HALF_LEN, 20'hFFFFF);
        write_reg(mvfe_pkg::CFG_HALF_WID, 20'hFFFFF);
        write_reg(mvfe_pkg::CFG_COUNTS, 20'hFFFFF);
        write_reg(mvfe_pkg::CFG_GEAR, 20'hFFFFF);
        run_phase(140);

        write_reg(mvfe_pkg::CFG_COUNTS, '0);
        run_phase(40);

        write_reg(mvfe_pkg::CFG_COUNTS, 20'd1);
        write_reg(mvfe_pkg::CFG_GEAR, '0);
        run_phase(40);

        // Smallest divisors: saturation on most items
        write_reg(mvfe_pkg::CFG_RADIUS, 20'd1);
        write_reg(mvfe_pkg::CFG_HALF_LEN, '0);
        write_reg(mvfe_pkg::CFG_HALF_WID, 20'd1);
        write_reg(mvfe_pkg::CFG_GEAR, 20'd1);
        run_phase(140);

        repeat (2) begin
            write_reg(mvfe_pkg::CFG_RADIUS, 20'($urandom_range(1, 20'hFFFFF)));
            write_reg(mvfe_pkg::CFG_HALF_LEN, 20'($urandom_range(0, 20'hFFFFF)));
            write_reg(mvfe_pkg::CFG_HALF_WID, 20'($urandom_range(0, 20'hFFFFF)));
            write_reg(mvfe_pkg::CFG_COUNTS, 20'($urandom_range(1, 16'hFFFF)));
            write_reg(mvfe_pkg::CFG_GEAR, 20'($urandom_range(1, 8'hFF)));
            run_phase(140);
        end

        write_reg(mvfe_pkg::CFG_RADIUS, mvfe_pkg::RADIUS_RST);
        write_reg(mvfe_pkg::CFG_HALF_LEN, mvfe_pkg::HALF_LEN_RST);
        write_reg(mvfe_pkg::CFG_HALF_WID, mvfe_pkg::HALF_WID_RST);
        write_reg(mvfe_pkg::CFG_COUNTS, 20'(mvfe_pkg::COUNTS_RST));
        write_reg(mvfe_pkg::CFG_GEAR, 20'(mvfe_pkg::GEAR_RST));
        run_phase(150);

        // Drain: catch any stray result after the last one
        repeat (60) @(posedge i_clk);
        if (velocity_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", velocity_q.size()));

        $display("encoder samples sent %0d, velocity results checked %0d",
                 accepted_count, results_checked);
        $display("register settings exercised %0d, mismatches %0d",
                 settings_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/mvfe_pkg.sv
hdl/mvfe_lane.sv
hdl/mecanum_velocity_from_encoders.sv
bench/tb.sv
